[hdl/rtc_clock_calendar_macros.svh]
// ---------------------------------------------------------------------------
// rtc_clock_calendar_macros.svh
// Assertion macros shared by the clock/calendar checker.
// ---------------------------------------------------------------------------
`ifndef RTC_CLOCK_CALENDAR_MACROS_SVH
`define RTC_CLOCK_CALENDAR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rtc_cal_pkg.sv]
// ---------------------------------------------------------------------------
// rtc_cal_pkg
// Types, limits and calendar helpers for the clock/calendar block.
// ---------------------------------------------------------------------------
package rtc_cal_pkg;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  localparam logic [3:0] SecOnesLimit = 4'd10;
  localparam logic [2:0] SecTensLimit = 3'd6;
  localparam logic [5:0] MinuteMax    = 6'd59;
  localparam logic [4:0] HourLimit    = 5'd24;
  localparam logic [3:0] MonthMax     = 4'd12;
  localparam logic [6:0] YearMax      = 7'd99;

  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthNov = 4'd11;

  localparam logic [4:0] DaysLong  = 5'd31;
  localparam logic [4:0] DaysShort = 5'd30;
  localparam logic [4:0] DaysLeap  = 5'd29;
  localparam logic [4:0] DaysFeb   = 5'd28;

  typedef struct packed {
    logic [3:0] sec_ones;
    logic [2:0] sec_tens;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } rtc_time_t;

  typedef struct packed {
    logic load;     // take the load fields
    logic advance;  // a second completed
  } rtc_ctrl_t;

  // Days in a month; month 0 and codes above 12 count as long months.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] y);
    logic [4:0] len;
    case (m)
      MonthFeb: len = (y[1:0] == 2'b00) ? DaysLeap : DaysFeb;
      MonthApr, MonthJun, MonthSep, MonthNov: len = DaysShort;
      default: len = DaysLong;
    endcase
    return len;
  endfunction

  // Tens digit of a 6-bit value (0..63 gives 0..6).
  function automatic logic [2:0] tens_of(input logic [5:0] s);
    logic [2:0] t;
    if (s >= 6'd60)      t = 3'd6;
    else if (s >= 6'd50) t = 3'd5;
    else if (s >= 6'd40) t = 3'd4;
    else if (s >= 6'd30) t = 3'd3;
    else if (s >= 6'd20) t = 3'd2;
    else if (s >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

endpackage

[hdl/rtc_cal_prescaler.sv]
// ---------------------------------------------------------------------------
// rtc_cal_prescaler
// Counts base ticks and flags the tick that completes a second.
// ---------------------------------------------------------------------------
module rtc_cal_prescaler #(
  parameter int unsigned TICKS_PER_SECOND = 100
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic tick_i,
  output logic sec_o
);

  localparam int unsigned CntW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam logic [CntW:0] Limit = (CntW + 1)'(TICKS_PER_SECOND);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW:0]   cnt_inc;
  logic            wrap;

  assign cnt_inc = {1'b0, cnt_q} + {{CntW{1'b0}}, 1'b1};
  assign wrap    = (cnt_inc >= Limit);
  assign sec_o   = tick_i & wrap;

  always_comb begin
    cnt_d = cnt_q;
    if (tick_i) begin
      cnt_d = wrap ? '0 : cnt_inc[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

[hdl/rtc_cal_next.sv]
// ---------------------------------------------------------------------------
// rtc_cal_next
// Next time/date: load of new fields or one-second carry cascade.
// ---------------------------------------------------------------------------
module rtc_cal_next (
  input  rtc_cal_pkg::rtc_ctrl_t ctrl_i,
  input  rtc_cal_pkg::rtc_time_t cur_i,
  input  logic [5:0]             load_seconds_i,
  input  logic [5:0]             load_minutes_i,
  input  logic [4:0]             load_hours_i,
  input  logic [4:0]             load_day_i,
  input  logic [3:0]             load_month_i,
  input  logic [6:0]             load_year_i,
  output rtc_cal_pkg::rtc_time_t nxt_o
);

  logic [2:0] ld_tens;
  logic [5:0] ld_tens_w;
  logic [5:0] ld_ones;

  assign ld_tens   = rtc_cal_pkg::tens_of(load_seconds_i);
  assign ld_tens_w = {3'b000, ld_tens};
  // ones = s - 10*tens
  assign ld_ones   = load_seconds_i - ((ld_tens_w << 3) + (ld_tens_w << 1));

  always_comb begin
    nxt_o = cur_i;
    if (ctrl_i.load) begin
      nxt_o.sec_ones = ld_ones[3:0];
      nxt_o.sec_tens = ld_tens;
      nxt_o.minute   = load_minutes_i;
      nxt_o.hour     = load_hours_i;
      nxt_o.day      = load_day_i;
      nxt_o.month    = load_month_i;
      nxt_o.year     = load_year_i;
    end else if (ctrl_i.advance) begin
      nxt_o.sec_ones = cur_i.sec_ones + 4'd1;
      if (nxt_o.sec_ones >= rtc_cal_pkg::SecOnesLimit) begin
        nxt_o.sec_ones = '0;
        nxt_o.sec_tens = cur_i.sec_tens + 3'd1;
        if (nxt_o.sec_tens >= rtc_cal_pkg::SecTensLimit) begin
          nxt_o.sec_tens = '0;
          nxt_o.minute   = cur_i.minute + 6'd1;
          if (nxt_o.minute > rtc_cal_pkg::MinuteMax) begin
            nxt_o.minute = '0;
            nxt_o.hour   = cur_i.hour + 5'd1;
          end
          // hour check runs on every minute carry, also for loaded hours
          if (nxt_o.hour >= rtc_cal_pkg::HourLimit) begin
            nxt_o.hour = '0;
            nxt_o.day  = cur_i.day + 5'd1;
          end
        end
      end
      // day/month check on every second
      if (nxt_o.month <= rtc_cal_pkg::MonthMax &&
          nxt_o.day > rtc_cal_pkg::month_len(nxt_o.month, nxt_o.year)) begin
        nxt_o.day   = 5'd1;
        nxt_o.month = nxt_o.month + 4'd1;
      end
      if (nxt_o.month > rtc_cal_pkg::MonthMax) begin
        nxt_o.month = 4'd1;
        nxt_o.year  = (nxt_o.year >= rtc_cal_pkg::YearMax) ? '0 : nxt_o.year + 7'd1;
      end
    end
  end

endmodule

[hdl/rtc_clock_calendar.sv]
// ---------------------------------------------------------------------------
// rtc_clock_calendar
// Real-time clock with calendar: base ticks and time/date loads in, the
// current time and date out after every transfer.
// ---------------------------------------------------------------------------
// Registered result: on the master side the cycle after the input transfer.
// Throughput: 1 transfer per cycle while the master side takes results; the
//   whole cascade (seconds through year) is combinational, state to result.
// A result waiting on a stalled master side still lets a new input in when
//   m_axis_tready_i is high in the same cycle.
// Reset (rst_ni low, async): 00:00:00, day 1, month 1, year 0, prescaler 0,
//   no result pending.
module rtc_clock_calendar #(
  parameter int unsigned TICKS_PER_SECOND = 100
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: load_seconds[5:0], load_minutes[11:6], load_hours[16:12],
  //        load_day[21:17], load_month[25:22], load_year[32:26], zero fill
  input  logic [rtc_cal_pkg::InDataW-1:0]  s_axis_tdata_i,
  // tuser: kind (0 = base tick, 1 = load time and date)
  input  logic                             s_axis_tuser_i,
  // Output stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: seconds_ones[3:0], seconds_tens[6:4], minutes[12:7], hours[17:13],
  //        day[22:18], month[26:23], year[33:27], zero fill
  output logic [rtc_cal_pkg::OutDataW-1:0] m_axis_tdata_o,
  // tuser: second_pulse (this tick completed a second)
  output logic                             m_axis_tuser_o
);

  // Clock/calendar state and its next value
  rtc_cal_pkg::rtc_time_t time_q, time_d;
  // Result register: one slot, refilled in the same cycle it drains
  rtc_cal_pkg::rtc_time_t res_q;
  logic                   pulse_q;
  logic                   res_valid_q;

  logic                   in_xfer;
  logic                   tick;
  logic                   sec_done;
  rtc_cal_pkg::rtc_ctrl_t ctrl;

  // Accept whenever the result slot is empty or being taken this cycle.
  assign s_axis_tready_o = ~res_valid_q | m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;
  assign tick            = in_xfer & ~s_axis_tuser_i;

  // Prescaler: flags the base tick that completes a second.
  rtc_cal_prescaler #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_prescaler (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tick_i(tick),
    .sec_o (sec_done)
  );

  assign ctrl.load    = in_xfer & s_axis_tuser_i;
  assign ctrl.advance = sec_done;

  // Load decode or carry cascade
  rtc_cal_next u_next (
    .ctrl_i        (ctrl),
    .cur_i         (time_q),
    .load_seconds_i(s_axis_tdata_i[5:0]),
    .load_minutes_i(s_axis_tdata_i[11:6]),
    .load_hours_i  (s_axis_tdata_i[16:12]),
    .load_day_i    (s_axis_tdata_i[21:17]),
    .load_month_i  (s_axis_tdata_i[25:22]),
    .load_year_i   (s_axis_tdata_i[32:26]),
    .nxt_o         (time_d)
  );

  // State: only moves on a load or a completed second.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '{sec_ones: 4'd0, sec_tens: 3'd0, minute: 6'd0, hour: 5'd0,
                  day: 5'd1, month: 4'd1, year: 7'd0};
    end else begin
      time_q <= time_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_xfer) begin
      res_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result payload: every transfer yields one snapshot of the new state.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q   <= time_d;
      pulse_q <= sec_done;
    end
  end

  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tuser_o  = pulse_q;
  assign m_axis_tdata_o  = {6'b000000, res_q.year, res_q.month, res_q.day, res_q.hour,
                            res_q.minute, res_q.sec_tens, res_q.sec_ones};

endmodule

[hdl/rtc_cal_checker.sv]
// ---------------------------------------------------------------------------
// rtc_cal_checker
// Port-level checks for the clock/calendar, bound to the top level.
// ---------------------------------------------------------------------------
`include "rtc_clock_calendar_macros.svh"

module rtc_cal_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [rtc_cal_pkg::InDataW-1:0]  s_axis_tdata_i,
  input logic                             s_axis_tuser_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [rtc_cal_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                             m_axis_tuser_o
);

  // stalled result holds
  `RTC_ASSERT_NXT(a_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

  // every input transfer produces a result next cycle
  `RTC_ASSERT_NXT(a_result, s_axis_tvalid_i && s_axis_tready_o, m_axis_tvalid_o, "result missing after transfer")

  // an empty result slot never blocks the input
  `RTC_ASSERT_IMP(a_ready, !m_axis_tvalid_o, s_axis_tready_o, "input blocked with empty result slot")

  // load shows loaded minutes/hours/date and no second pulse
  `RTC_ASSERT_NXT(a_load, s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i, !m_axis_tuser_o && m_axis_tdata_o[33:7] == $past(s_axis_tdata_i[32:6]), "load not reflected in result")

endmodule

bind rtc_clock_calendar rtc_cal_checker u_rtc_cal_checker (.*);

[dv/rtc_tb_pkg.sv]
// ---------------------------------------------------------------------------
// rtc_tb_pkg
// Codes and the load-word layout shared by the clock/calendar testbench files.
// ---------------------------------------------------------------------------
package rtc_tb_pkg;

  // Prescaler setting the block is built with in this bench.
  localparam int unsigned TicksPerSecond = 100;

  // tuser on the input side.
  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } rtc_kind_e;

  // Load fields as they sit in s_axis_tdata, seconds in the lowest bits.
  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } rtc_load_t;

endpackage

[dv/rtc_calendar_checker.sv]
// ---------------------------------------------------------------------------
// rtc_calendar_checker
// Watches both streams of the clock/calendar block, keeps its own clock and
// calendar, and compares every result transfer field by field in order.
// ---------------------------------------------------------------------------
module rtc_calendar_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [rtc_cal_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                             s_tuser_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  input  logic [rtc_cal_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                             m_tuser_i,
  output int                               mismatch_count_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    rtc_cal_pkg::rtc_time_t now;
    logic                   pulse;
  } rtc_reading_t;

  rtc_cal_pkg::rtc_time_t cal;
  int unsigned            prescale;
  rtc_reading_t           readings_due[$];
  int                     results_seen;

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
    results_seen     = 0;
  end

  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [6:0] y);
    logic [4:0] len;
    case (m)
      4'd2:                      len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // One completed second; counters wrap at their own widths.
  function automatic void advance_second();
    cal.sec_ones = cal.sec_ones + 4'd1;
    if (cal.sec_ones >= 4'd10) begin
      cal.sec_ones = 4'd0;
      cal.sec_tens = cal.sec_tens + 3'd1;
      if (cal.sec_tens >= 3'd6) begin
        cal.sec_tens = 3'd0;
        cal.minute   = cal.minute + 6'd1;
        if (cal.minute > 6'd59) begin
          cal.minute = 6'd0;
          cal.hour   = cal.hour + 5'd1;
        end
        // hour checked on every minute carry, also after an oversize load
        if (cal.hour >= 5'd24) begin
          cal.hour = 5'd0;
          cal.day  = cal.day + 5'd1;
        end
      end
    end
    // month codes above 12 skip the day check
    if (cal.month <= 4'd12 && cal.day > days_in_month(cal.month, cal.year)) begin
      cal.day   = 5'd1;
      cal.month = cal.month + 4'd1;
    end
    if (cal.month > 4'd12) begin
      cal.month = 4'd1;
      cal.year  = (cal.year >= 7'd99) ? 7'd0 : cal.year + 7'd1;
    end
  endfunction

  function automatic rtc_reading_t step_clock(input logic kind,
                                              input rtc_tb_pkg::rtc_load_t ld);
    rtc_reading_t r;
    r.pulse = 1'b0;
    if (kind == rtc_tb_pkg::KIND_LOAD) begin
      // prescaler phase is kept across a load
      cal.sec_ones = 4'(ld.second % 6'd10);
      cal.sec_tens = 3'(ld.second / 6'd10);
      cal.minute   = ld.minute;
      cal.hour     = ld.hour;
      cal.day      = ld.day;
      cal.month    = ld.month;
      cal.year     = ld.year;
    end else begin
      prescale = prescale + 1;
      if (prescale >= rtc_tb_pkg::TicksPerSecond) begin
        prescale = 0;
        r.pulse  = 1'b1;
        advance_second();
      end
    end
    r.now = cal;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10)
        $display("%0t ns: result %0d %s expected %0d got %0d",
                 $realtime, results_seen, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : watch
    rtc_tb_pkg::rtc_load_t ld;
    rtc_reading_t          got;
    rtc_reading_t          want;
    if (!rst_ni) begin
      cal.sec_ones = 4'd0;
      cal.sec_tens = 3'd0;
      cal.minute   = 6'd0;
      cal.hour     = 5'd0;
      cal.day      = 5'd1;
      cal.month    = 4'd1;
      cal.year     = 7'd0;
      prescale     = 0;
      readings_due.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        ld = s_tdata_i[$bits(rtc_tb_pkg::rtc_load_t)-1:0];
        readings_due.push_back(step_clock(s_tuser_i, ld));
      end
      if (m_tvalid_i && m_tready_i) begin
        got.now.sec_ones = m_tdata_i[3:0];
        got.now.sec_tens = m_tdata_i[6:4];
        got.now.minute   = m_tdata_i[12:7];
        got.now.hour     = m_tdata_i[17:13];
        got.now.day      = m_tdata_i[22:18];
        got.now.month    = m_tdata_i[26:23];
        got.now.year     = m_tdata_i[33:27];
        got.pulse        = m_tuser_i;
        if (readings_due.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t ns: result transfer with none outstanding, tdata %h tuser %b",
                     $realtime, m_tdata_i, m_tuser_i);
        end else begin
          want = readings_due.pop_front();
          check_field("seconds_ones", 32'(want.now.sec_ones), 32'(got.now.sec_ones));
          check_field("seconds_tens", 32'(want.now.sec_tens), 32'(got.now.sec_tens));
          check_field("minutes", 32'(want.now.minute), 32'(got.now.minute));
          check_field("hours", 32'(want.now.hour), 32'(got.now.hour));
          check_field("day", 32'(want.now.day), 32'(got.now.day));
          check_field("month", 32'(want.now.month), 32'(got.now.month));
          check_field("year", 32'(want.now.year), 32'(got.now.year));
          check_field("second_pulse", 32'(want.pulse), 32'(got.pulse));
        end
        results_seen++;
      end
    end
    pending_o = readings_due.size();
  end

endmodule

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the clock/calendar block: directed loads at the
// calendar edges, then random load/tick sequences driven into second
// rollovers, with random idling on both streams and a checker alongside.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LongHold   = 300;  // receiver hold-off, cycles
  localparam int unsigned NumItems   = 650;  // input transfers, roughly
  localparam int unsigned QuietItems = 120;  // closing stretch without idling

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [rtc_cal_pkg::InDataW-1:0]  s_tdata;
  logic                             s_tuser;
  logic                             m_tvalid;
  logic                             m_tready;
  logic [rtc_cal_pkg::OutDataW-1:0] m_tdata;
  logic                             m_tuser;
  int                               mismatches;
  int                               pending;

  // Stimulus bookkeeping. The prescaler phase is known from the tick count
  // alone (loads leave it alone), so sequences can run straight into a
  // second rollover right after a load.
  int unsigned tick_phase;
  int unsigned items_sent;
  bit          quiet;     // end of run: no idling on either side
  bit          calm;      // per-sequence stretch without idling
  bit          hold_req;  // ask the receiver for one long hold-off

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  rtc_clock_calendar #(
    .TICKS_PER_SECOND(rtc_tb_pkg::TicksPerSecond)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  rtc_calendar_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .s_tuser_i        (s_tuser),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .m_tuser_i        (m_tuser),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  function automatic rtc_tb_pkg::rtc_load_t mk_load(input int s, input int mi, input int h,
                                                    input int d, input int mo, input int y);
    rtc_tb_pkg::rtc_load_t ld;
    ld.second = 6'(s);
    ld.minute = 6'(mi);
    ld.hour   = 5'(h);
    ld.day    = 5'(d);
    ld.month  = 4'(mo);
    ld.year   = 7'(y);
    return ld;
  endfunction

  // Any value each field can hold, in range or not.
  function automatic rtc_tb_pkg::rtc_load_t full_load();
    return mk_load($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 127));
  endfunction

  // Mostly one step short of a rollover somewhere in the cascade.
  function automatic rtc_tb_pkg::rtc_load_t edge_load();
    rtc_tb_pkg::rtc_load_t ld;
    ld = full_load();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: ld.second = 6'd59;
      4:          ld.second = 6'($urandom_range(0, 5) * 10 + 9);
      5:          ld.second = 6'($urandom_range(60, 63));
      default:    ;
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 3: ld.minute = 6'd59;
      4:          ld.minute = 6'($urandom_range(60, 63));
      default:    ;
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 3: ld.hour = 5'd23;
      4:          ld.hour = 5'($urandom_range(24, 31));
      default:    ;
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2: ld.month = 4'd12;
      3:       ld.month = 4'd2;
      4: begin
        case ($urandom_range(0, 3))
          0:       ld.month = 4'd4;
          1:       ld.month = 4'd6;
          2:       ld.month = 4'd9;
          default: ld.month = 4'd11;
        endcase
      end
      5:       ld.month = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4: ld.day = 5'($urandom_range(28, 31));
      5:             ld.day = 5'd0;
      default:       ;
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2: ld.year = 7'd99;
      3:       ld.year = 7'($urandom_range(100, 127));
      4:       ld.year = 7'($urandom_range(0, 24) * 4);  // leap year
      default: ;
    endcase
    return ld;
  endfunction

  // One input transfer. Entered and left just after a falling edge, so
  // tvalid is assigned once per time step.
  task automatic send_item(input rtc_tb_pkg::rtc_kind_e kind,
                           input rtc_tb_pkg::rtc_load_t ld);
    logic [rtc_cal_pkg::InDataW-1:0] word;
    word = '0;
    word[$bits(rtc_tb_pkg::rtc_load_t)-1:0] = ld;
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= kind;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    items_sent++;
    if (kind == rtc_tb_pkg::KIND_TICK) begin
      tick_phase++;
      if (tick_phase >= rtc_tb_pkg::TicksPerSecond) begin
        tick_phase = 0;
      end
    end
  endtask

  // Ticks (with junk in the ignored load fields) up to and including the
  // next completed second.
  task automatic roll_second();
    do send_item(rtc_tb_pkg::KIND_TICK, full_load()); while (tick_phase != 0);
  endtask

  task automatic load_and_roll(input rtc_tb_pkg::rtc_load_t ld);
    send_item(rtc_tb_pkg::KIND_LOAD, ld);
    roll_second();
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  // Run limit, far above the slowest passing run.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = rtc_tb_pkg::KIND_TICK;
    tick_phase  = 0;
    items_sent  = 0;
    quiet       = 1'b0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset state, then loads one step before a rollover.
    send_item(rtc_tb_pkg::KIND_TICK, '0);
    // receiver sits for a long stretch while the sender keeps offering a load and then ticks
    hold_req = 1'b1;
    load_and_roll(mk_load(59, 59, 23, 31, 12, 99));   // year wraps to 0
    // sender waits until every result is back
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    load_and_roll(mk_load(59, 59, 23, 29, 2, 96));    // leap February ends
    load_and_roll(mk_load(63, 63, 31, 31, 15, 127));  // every field at its top code
    load_and_roll(mk_load(59, 59, 23, 28, 2, 97));    // plain February ends

    // Random: mostly edge loads run into a second; some noise, some loads
    // landing mid-prescale, some plain random loads.
    while (items_sent + rtc_tb_pkg::TicksPerSecond < NumItems) begin
      quiet = (items_sent + rtc_tb_pkg::TicksPerSecond + QuietItems >= NumItems);
      calm  = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 15) == 0) begin
        // drain: sender waits until every result is back
        s_tvalid <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          load_and_roll(edge_load());
          repeat ($urandom_range(0, 3)) send_item(rtc_tb_pkg::KIND_TICK, full_load());
        end
        6: load_and_roll(full_load());
        7: begin
          load_and_roll(edge_load());
          roll_second();
        end
        8: begin
          repeat ($urandom_range(1, 8))
            send_item($urandom_range(0, 1) ? rtc_tb_pkg::KIND_LOAD
                                           : rtc_tb_pkg::KIND_TICK, full_load());
        end
        default: begin
          send_item(rtc_tb_pkg::KIND_LOAD, edge_load());
          repeat ($urandom_range(1, 20)) send_item(rtc_tb_pkg::KIND_TICK, full_load());
          load_and_roll(edge_load());
        end
      endcase
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/rtc_cal_pkg.sv
hdl/rtc_cal_prescaler.sv
hdl/rtc_cal_next.sv
hdl/rtc_clock_calendar.sv
hdl/rtc_cal_checker.sv
dv/rtc_tb_pkg.sv
dv/rtc_calendar_checker.sv
dv/testbench.sv
